FILE: rtl/r6m_pkg.sv
// shared types and constants for the 6d rotation to matrix converter
`timescale 1ns / 1ps
`default_nettype none
package r6m_pkg;

	localparam int COMP_W     = 16;   // q4.12 input and q1.14 output component
	localparam int M_W        = 17;   // magnitude of a 16 bit signed value
	localparam int SQF_W      = 34;   // full product of two magnitudes
	localparam int SQ_W       = 31;   // square of a magnitude, at most 2^30
	localparam int SUM_W      = 32;   // sum of three squares
	localparam int Q_W        = 15;   // unit magnitude, 0..16384
	localparam int SRCH_STEPS = 15;   // one result bit per search stage
	localparam int ES_W       = 48;   // running 2q * sum
	localparam int D_W        = 68;   // signed search remainder
	localparam int FRAC_SHIFT = 30;
	localparam int PROD_W     = 32;
	localparam int DOT_W      = 32;
	localparam int DOT_SUM_W  = 34;
	localparam int DA_W       = 48;
	localparam int B_W        = 48;
	localparam int MAG_W      = 47;
	localparam int K_W        = 6;
	localparam int WM_W       = 15;
	localparam int RES_SHIFT  = 28;
	localparam int RND_SHIFT  = 14;
	localparam int ONE_Q14    = 16384;

	typedef logic [2:0][COMP_W-1:0] vec3_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_FIRST_DEGEN  = 2'd1,
		ST_SECOND_DEGEN = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} norm_stat_t;

endpackage
`default_nettype wire

FILE: rtl/r6m_norm.sv
// pipelined exact unit-vector scaling of a 3-vector to q1.14
`timescale 1ns / 1ps
`default_nettype none
module r6m_norm #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  r6m_pkg::vec3_t      vec_in,
	input  logic [SIDE_W-1:0]   side_in,
	output r6m_pkg::norm_stat_t stat,
	output r6m_pkg::vec3_t      unit_out,
	output logic [SIDE_W-1:0]   side_out
);
	import r6m_pkg::*;

	logic              valid_s1;
	logic [2:0]        neg_s1;
	logic [SQ_W-1:0]   sq_s1 [3];
	logic [SIDE_W-1:0] side_s1;
	logic [SQ_W-1:0]   sq_d [3];

	// search pipeline, index 0 is the stage after the sum
	logic              srch_v_s    [SRCH_STEPS+1];
	logic signed [D_W-1:0] srch_d_s [SRCH_STEPS+1][3];
	logic [ES_W-1:0]   srch_es_s   [SRCH_STEPS+1][3];
	logic [Q_W-1:0]    srch_q_s    [SRCH_STEPS+1][3];
	logic [SUM_W-1:0]  srch_sum_s  [SRCH_STEPS+1];
	logic [2:0]        srch_neg_s  [SRCH_STEPS+1];
	logic [SIDE_W-1:0] srch_side_s [SRCH_STEPS+1];

	always_comb begin : mag_sq
		logic [M_W-1:0]   m;
		logic [SQF_W-1:0] sqf;
		for (int i = 0; i < 3; i++) begin
			m = vec_in[i][COMP_W-1] ? (M_W'({1'b0, ~vec_in[i]}) + M_W'(1)) :
				M_W'(vec_in[i]);
			sqf = SQF_W'(m) * SQF_W'(m);
			sq_d[i] = sqf[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			srch_v_s[0] <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			srch_v_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_in[i][COMP_W-1];
				sq_s1[i]  <= sq_d[i];
			end
			srch_sum_s[0]  <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			srch_neg_s[0]  <= neg_s1;
			srch_side_s[0] <= side_s1;
			for (int i = 0; i < 3; i++) begin
				srch_d_s[0][i]  <= D_W'(sq_s1[i]) << FRAC_SHIFT;
				srch_es_s[0][i] <= '0;
				srch_q_s[0][i]  <= '0;
			end
		end
	end

	// each stage tries one bit of q, remainder kept against (2q)^2 * sum
	for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_step
		localparam int BP = Q_W - 1 - j;
		logic signed [D_W-1:0] y [3];
		logic signed [D_W-1:0] z [3];
		logic signed [D_W-1:0] tr [3];
		logic signed [D_W-1:0] dn [3];
		logic [ES_W-1:0]       esn [3];
		logic [Q_W-1:0]        qn [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				y[i]  = (D_W'(srch_es_s[j][i]) << 1) + (D_W'(srch_sum_s[j]) << (BP + 1));
				z[i]  = y[i] - D_W'(srch_sum_s[j]);
				tr[i] = (z[i] << (BP + 1)) - z[i];
				dn[i]  = srch_d_s[j][i];
				esn[i] = srch_es_s[j][i];
				qn[i]  = srch_q_s[j][i];
				if (tr[i] <= srch_d_s[j][i]) begin
					dn[i]     = srch_d_s[j][i] - (y[i] << (BP + 1));
					esn[i]    = srch_es_s[j][i] + (ES_W'(srch_sum_s[j]) << (BP + 1));
					qn[i][BP] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				srch_v_s[j+1] <= 1'b0;
			end else if (en) begin
				srch_v_s[j+1] <= srch_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srch_sum_s[j+1]  <= srch_sum_s[j];
				srch_neg_s[j+1]  <= srch_neg_s[j];
				srch_side_s[j+1] <= srch_side_s[j];
				for (int i = 0; i < 3; i++) begin
					srch_d_s[j+1][i]  <= dn[i];
					srch_es_s[j+1][i] <= esn[i];
					srch_q_s[j+1][i]  <= qn[i];
				end
			end
		end
	end

	always_comb begin : apply_sign
		logic [COMP_W-1:0] qq;
		for (int i = 0; i < 3; i++) begin
			qq = COMP_W'(srch_q_s[SRCH_STEPS][i]);
			unit_out[i] = srch_neg_s[SRCH_STEPS][i] ? (~qq + 1'b1) : qq;
		end
	end

	assign stat.valid = srch_v_s[SRCH_STEPS];
	assign stat.zero  = (srch_sum_s[SRCH_STEPS] == '0);
	assign side_out   = srch_side_s[SRCH_STEPS];

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.valid && !stat.zero) |->
			(srch_q_s[SRCH_STEPS][0] <= Q_W'(ONE_Q14)) &&
			(srch_q_s[SRCH_STEPS][1] <= Q_W'(ONE_Q14)) &&
			(srch_q_s[SRCH_STEPS][2] <= Q_W'(ONE_Q14)))
		else $error("unit magnitude above one");

	a_full_scale_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.valid && !stat.zero && srch_q_s[SRCH_STEPS][0][Q_W-1]) |->
			(srch_q_s[SRCH_STEPS][0][Q_W-2:0] == '0))
		else $error("full scale component carries lower bits");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stat.valid) && $stable(unit_out))
		else $error("search pipeline moved during stall");

endmodule
`default_nettype wire

FILE: rtl/rotation_6d_to_matrix_top.sv
// top level of the 6d rotation to 3x3 rotation matrix converter
`timescale 1ns / 1ps
`default_nettype none
// converts two q4.12 3-vectors into an orthonormal q1.14 rotation matrix by
// gram-schmidt: row 0 is the first vector scaled to unit length, row 1 is the
// second vector with its row-0 component removed and scaled to unit length,
// row 2 is row0 x row1. one request is taken every clock while the pipeline advances,
// and a result passes through two 17-stage normalizers (a 15-stage bit-per-stage exact
// search each), eight projection stages between them and two cross product
// stages at the end. the whole pipeline advances together and freezes only
// while the output register holds a result that is not taken, so no request
// is lost or repeated. an all-zero first vector reports status 1, a second
// vector with nothing left after the projection reports status 2; both give
// all-zero rows.
module rotation_6d_to_matrix_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] first_x,
	input  logic [15:0] first_y,
	input  logic [15:0] first_z,
	input  logic [15:0] second_x,
	input  logic [15:0] second_y,
	input  logic [15:0] second_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] row0_x,
	output logic [15:0] row0_y,
	output logic [15:0] row0_z,
	output logic [15:0] row1_x,
	output logic [15:0] row1_y,
	output logic [15:0] row1_z,
	output logic [15:0] row2_x,
	output logic [15:0] row2_y,
	output logic [15:0] row2_z,
	output logic [1:0]  status
);
	import r6m_pkg::*;

	localparam int SIDE_A_W = $bits(vec3_t);
	localparam int SIDE_B_W = $bits(vec3_t) + 1;

	// global advance: the output register is empty or being drained
	logic en;

	vec3_t      vf, vs;
	norm_stat_t stat_a, stat_b;
	vec3_t      a_out, s_out, b_out, a_side;
	logic       zf_side;

	// projection stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic zf_s1, zf_s2, zf_s3, zf_s4, zf_s5, zf_s6, zf_s7, zf_s8;
	vec3_t a_s1, a_s2, a_s3, a_s4, a_s5, a_s6, a_s7, a_s8;
	vec3_t s_s1, s_s2, s_s3;
	logic signed [PROD_W-1:0] prod_s1 [3];
	logic signed [DOT_W-1:0]  dot_s2;
	logic signed [DA_W-1:0]   da_s3 [3];
	logic signed [B_W-1:0]    b_s4 [3];
	logic [MAG_W-1:0]         mag_s5 [3], mag_s6 [3], mag_s7 [3];
	logic [2:0]               negb_s5, negb_s6, negb_s7;
	logic [MAG_W-1:0]         mx_s6;
	logic [K_W-1:0]           k_s7;
	vec3_t                    w_s8;

	// cross product and output stages
	logic v_s9, v_s10;
	logic zf_s9, zb_s9;
	vec3_t a_s9, b_s9;
	logic signed [PROD_W-1:0] cp_s9 [6];
	vec3_t r0_s10, r1_s10, r2_s10;
	status_t st_s10;

	assign en       = !v_s10 || out_ready;
	assign in_ready = en;

	assign vf = {first_z, first_y, first_x};
	assign vs = {second_z, second_y, second_x};

	// first vector to row 0, second vector rides along
	r6m_norm #(.SIDE_W(SIDE_A_W)) u_norm_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.vec_in   (vf),
		.side_in  (vs),
		.stat     (stat_a),
		.unit_out (a_out),
		.side_out (s_out)
	);

	// projection datapath
	logic signed [DOT_SUM_W-1:0] dot_full;
	logic signed [B_W-1:0]       s_sh [3];
	logic [MAG_W-1:0]            mag_d [3];
	logic [MAG_W-1:0]            mx_d;
	logic [K_W-1:0]              k_d;
	vec3_t                       w_d;

	always_comb begin
		dot_full = DOT_SUM_W'(prod_s1[0]) + DOT_SUM_W'(prod_s1[1]) + DOT_SUM_W'(prod_s1[2]);
		for (int i = 0; i < 3; i++) begin
			s_sh[i]  = B_W'($signed(s_s3[i])) <<< RES_SHIFT;
			mag_d[i] = b_s4[i][B_W-1] ? MAG_W'(-b_s4[i]) : MAG_W'(b_s4[i]);
		end
		mx_d = (mag_s5[0] > mag_s5[1]) ? mag_s5[0] : mag_s5[1];
		if (mag_s5[2] > mx_d) begin
			mx_d = mag_s5[2];
		end
		// smallest shift that brings the largest residual under 2^15
		k_d = '0;
		for (int i = WM_W; i < MAG_W; i++) begin
			if (mx_s6[i]) begin
				k_d = K_W'(i - (WM_W - 1));
			end
		end
	end

	always_comb begin : scale_down
		logic [WM_W-1:0]   wm;
		logic [COMP_W-1:0] wv;
		for (int i = 0; i < 3; i++) begin
			wm = WM_W'(mag_s7[i] >> k_s7);
			wv = COMP_W'(wm);
			w_d[i] = negb_s7[i] ? (~wv + 1'b1) : wv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= stat_a.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// dot product terms of row 0 and the second vector
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PROD_W'($signed(a_out[i])) * PROD_W'($signed(s_out[i]));
			end
			a_s1  <= a_out;
			s_s1  <= s_out;
			zf_s1 <= stat_a.zero;
			// dot product
			dot_s2 <= dot_full[DOT_W-1:0];
			a_s2   <= a_s1;
			s_s2   <= s_s1;
			zf_s2  <= zf_s1;
			// projection onto row 0
			for (int i = 0; i < 3; i++) begin
				da_s3[i] <= DA_W'(dot_s2) * DA_W'($signed(a_s2[i]));
			end
			a_s3  <= a_s2;
			s_s3  <= s_s2;
			zf_s3 <= zf_s2;
			// exact residual at scale 2^40
			for (int i = 0; i < 3; i++) begin
				b_s4[i] <= s_sh[i] - da_s3[i];
			end
			a_s4  <= a_s3;
			zf_s4 <= zf_s3;
			// magnitudes
			for (int i = 0; i < 3; i++) begin
				mag_s5[i]  <= mag_d[i];
				negb_s5[i] <= b_s4[i][B_W-1];
			end
			a_s5  <= a_s4;
			zf_s5 <= zf_s4;
			// largest magnitude
			mx_s6   <= mx_d;
			mag_s6  <= mag_s5;
			negb_s6 <= negb_s5;
			a_s6    <= a_s5;
			zf_s6   <= zf_s5;
			// shift amount
			k_s7    <= k_d;
			mag_s7  <= mag_s6;
			negb_s7 <= negb_s6;
			a_s7    <= a_s6;
			zf_s7   <= zf_s6;
			// truncated residual, fits 16 bits signed
			w_s8  <= w_d;
			a_s8  <= a_s7;
			zf_s8 <= zf_s7;
		end
	end

	// residual to row 1, row 0 and first-vector flag ride along
	r6m_norm #(.SIDE_W(SIDE_B_W)) u_norm_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.vec_in   (w_s8),
		.side_in  ({zf_s8, a_s8}),
		.stat     (stat_b),
		.unit_out (b_out),
		.side_out ({zf_side, a_side})
	);

	// cross product rounding to q1.14 with saturation
	function automatic logic [COMP_W-1:0] round_sat(
		input logic signed [PROD_W-1:0] p,
		input logic signed [PROD_W-1:0] m
	);
		logic signed [PROD_W:0]   x;
		logic signed [PROD_W:0]   r;
		x = (PROD_W + 1)'(p) - (PROD_W + 1)'(m) + (PROD_W + 1)'(ONE_Q14 / 2);
		r = x >>> RND_SHIFT;
		if (r > (PROD_W + 1)'(ONE_Q14)) begin
			r = (PROD_W + 1)'(ONE_Q14);
		end else if (r < -(PROD_W + 1)'(ONE_Q14)) begin
			r = -(PROD_W + 1)'(ONE_Q14);
		end
		return r[COMP_W-1:0];
	endfunction

	vec3_t   r2_d;
	status_t st_d;

	always_comb begin
		r2_d[0] = round_sat(cp_s9[0], cp_s9[1]);
		r2_d[1] = round_sat(cp_s9[2], cp_s9[3]);
		r2_d[2] = round_sat(cp_s9[4], cp_s9[5]);
		priority if (zf_s9) begin
			st_d = ST_FIRST_DEGEN;
		end else if (zb_s9) begin
			st_d = ST_SECOND_DEGEN;
		end else begin
			st_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s9  <= stat_b.valid;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// six products of row0 x row1
			cp_s9[0] <= PROD_W'($signed(a_side[1])) * PROD_W'($signed(b_out[2]));
			cp_s9[1] <= PROD_W'($signed(a_side[2])) * PROD_W'($signed(b_out[1]));
			cp_s9[2] <= PROD_W'($signed(a_side[2])) * PROD_W'($signed(b_out[0]));
			cp_s9[3] <= PROD_W'($signed(a_side[0])) * PROD_W'($signed(b_out[2]));
			cp_s9[4] <= PROD_W'($signed(a_side[0])) * PROD_W'($signed(b_out[1]));
			cp_s9[5] <= PROD_W'($signed(a_side[1])) * PROD_W'($signed(b_out[0]));
			a_s9  <= a_side;
			b_s9  <= b_out;
			zf_s9 <= zf_side;
			zb_s9 <= stat_b.zero;
			// output register, rows cleared on a degenerate request
			st_s10 <= st_d;
			r0_s10 <= (st_d == ST_OK) ? a_s9 : '0;
			r1_s10 <= (st_d == ST_OK) ? b_s9 : '0;
			r2_s10 <= (st_d == ST_OK) ? r2_d : '0;
		end
	end

	assign out_valid = v_s10;
	assign status    = st_s10;
	assign row0_x    = r0_s10[0];
	assign row0_y    = r0_s10[1];
	assign row0_z    = r0_s10[2];
	assign row1_x    = r1_s10[0];
	assign row1_y    = r1_s10[1];
	assign row1_z    = r1_s10[2];
	assign row2_x    = r2_s10[0];
	assign row2_y    = r2_s10[1];
	assign row2_z    = r2_s10[2];

	a_degen_rows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && st_s10 != ST_OK) |->
			(r0_s10 == '0) && (r1_s10 == '0) && (r2_s10 == '0))
		else $error("degenerate result with nonzero rows");

	a_residual_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (w_s8[0] != 16'h8000) && (w_s8[1] != 16'h8000) &&
			(w_s8[2] != 16'h8000))
		else $error("scaled residual out of range");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9}))
		else $error("projection pipeline moved during stall");

endmodule
`default_nettype wire
